/* sv/tcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_pkg
// Types and constants shared by the trusted clock guard.
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int TIME_W     = 32;
    localparam int NUDGE_W    = 17;
    localparam int INTERVAL_W = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 104;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 72;

    localparam logic [TIME_W-1:0]     BUILD_FLOOR_RST   = 32'd1700000000;
    localparam logic [NUDGE_W-1:0]    MAX_NUDGE_RST     = 17'd300;
    localparam logic [INTERVAL_W-1:0] MARK_INTERVAL_RST = 20'd21600;
    localparam logic [TIME_W-1:0]     EPOCH_CEILING_RST = 32'd4102444800;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_CLOCK  = 3'd1,
        ST_STOPPED   = 3'd2,
        ST_NEVER_SET = 3'd3,
        ST_BACKWARDS = 3'd4
    } trust_state_t;

    typedef enum logic [1:0] {
        ACT_BOOT = 2'd0,
        ACT_READ = 2'd1,
        ACT_SET  = 2'd2
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BUILD_FLOOR   = 2'd0,
        REG_MAX_NUDGE     = 2'd1,
        REG_MARK_INTERVAL = 2'd2,
        REG_EPOCH_CEILING = 2'd3
    } cfg_index_t;

endpackage

/* sv/trusted_clock_guard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trusted_clock_guard
// Tracks the trust state of a real-time clock against a high-water mark.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one event: a boot evaluation, a clock read
// or a set-time request, selected by s_tuser. Every request yields exactly one
// result on the m_ channel with the new trust state, the returned time, the
// acceptance flag, the current mark and the storage write flags.
// A request is held in an input register, evaluated against the trust state
// and the mark by compare logic, and lands in a result register, from which it
// is offered on m_tvalid. One request is taken every cycle while the receiver
// does not stall; the trust state and the mark change on the same edge that
// registers each result. While the receiver stalls, the result register holds
// its data and one more request still waits in the input register, so
// s_tready drops only when both are full. Reset clears both valid flags,
// restores the four configuration registers to their defaults, sets the state
// to no clock and clears the mark. Configuration writes through cfg_wr_en take
// effect at the next edge and belong to idle periods.
// ----------------------------------------------------------------------------
module trusted_clock_guard (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [tcg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [tcg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // rtc_present, osf_flag, provisioned, stored_mark, rtc_time, set_epoch.
    input  logic [tcg_pkg::S_TDATA_W-1:0]        s_tdata,
    // action.
    input  logic [tcg_pkg::S_TUSER_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // trust state, time_out, accepted, persist_mark, mark_value,
    // persist_provisioned.
    output logic [tcg_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int TW = tcg_pkg::TIME_W;

    logic [TW-1:0]                   build_floor_reg;
    logic [tcg_pkg::NUDGE_W-1:0]     max_nudge_reg;
    logic [tcg_pkg::INTERVAL_W-1:0]  mark_interval_reg;
    logic [TW-1:0]                   epoch_ceiling_reg;

    tcg_pkg::trust_state_t trust_state_reg, trust_state_next;
    logic [TW-1:0]         high_mark_reg, high_mark_next;

    logic                  in_valid_reg;
    logic [1:0]            in_action_reg;
    logic                  in_present_reg, in_osf_reg, in_prov_reg;
    logic [TW-1:0]         in_stored_reg, in_now_reg, in_epoch_reg;

    logic                  out_valid_reg;
    tcg_pkg::trust_state_t out_state_reg;
    logic [TW-1:0]         out_time_reg, out_mark_reg;
    logic                  out_accepted_reg, out_pmark_reg, out_pprov_reg;

    logic [TW-1:0] time_next;
    logic          accepted_next, pmark_next, pprov_next;
    logic          fire, in_take;

    logic [TW-1:0] delta_abs;
    logic [TW:0]   mark_plus_interval, epoch_plus_nudge;
    logic          nudge_ok, floor_ok, ceil_ok, mark_ok, set_ok;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            build_floor_reg   <= tcg_pkg::BUILD_FLOOR_RST;
            max_nudge_reg     <= tcg_pkg::MAX_NUDGE_RST;
            mark_interval_reg <= tcg_pkg::MARK_INTERVAL_RST;
            epoch_ceiling_reg <= tcg_pkg::EPOCH_CEILING_RST;
        end else if (cfg_wr_en) begin
            case (tcg_pkg::cfg_index_t'(cfg_addr))
                tcg_pkg::REG_BUILD_FLOOR:   build_floor_reg   <= cfg_wdata;
                tcg_pkg::REG_MAX_NUDGE:
                    max_nudge_reg <= cfg_wdata[tcg_pkg::NUDGE_W-1:0];
                tcg_pkg::REG_MARK_INTERVAL:
                    mark_interval_reg <= cfg_wdata[tcg_pkg::INTERVAL_W-1:0];
                tcg_pkg::REG_EPOCH_CEILING: epoch_ceiling_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_take) begin
            in_action_reg  <= s_tuser;
            in_present_reg <= s_tdata[0];
            in_osf_reg     <= s_tdata[1];
            in_prov_reg    <= s_tdata[2];
            in_stored_reg  <= s_tdata[34:3];
            in_now_reg     <= s_tdata[66:35];
            in_epoch_reg   <= s_tdata[98:67];
        end
    end

    assign delta_abs = (in_epoch_reg >= in_now_reg) ? (in_epoch_reg - in_now_reg)
                                                    : (in_now_reg - in_epoch_reg);
    assign nudge_ok  = delta_abs <= {{(TW-tcg_pkg::NUDGE_W){1'b0}}, max_nudge_reg};
    assign floor_ok  = in_epoch_reg >= build_floor_reg;
    assign ceil_ok   = in_epoch_reg <= epoch_ceiling_reg;
    assign epoch_plus_nudge = {1'b0, in_epoch_reg}
                            + {{(TW+1-tcg_pkg::NUDGE_W){1'b0}}, max_nudge_reg};
    assign mark_ok   = epoch_plus_nudge >= {1'b0, high_mark_reg};
    assign mark_plus_interval = {1'b0, high_mark_reg}
                              + {{(TW+1-tcg_pkg::INTERVAL_W){1'b0}}, mark_interval_reg};
    assign set_ok = (trust_state_reg != tcg_pkg::ST_NO_CLOCK) && floor_ok && ceil_ok
                 && ((trust_state_reg != tcg_pkg::ST_OK) || nudge_ok) && mark_ok;

    always_comb begin
        trust_state_next = trust_state_reg;
        high_mark_next   = high_mark_reg;
        time_next        = '0;
        accepted_next    = 1'b1;
        pmark_next       = 1'b0;
        pprov_next       = 1'b0;
        case (tcg_pkg::action_t'(in_action_reg))
            tcg_pkg::ACT_BOOT: begin
                high_mark_next = in_stored_reg;
                time_next      = in_now_reg;
                if (!in_present_reg) begin
                    trust_state_next = tcg_pkg::ST_NO_CLOCK;
                end else if (in_osf_reg) begin
                    trust_state_next = tcg_pkg::ST_STOPPED;
                end else if (!in_prov_reg) begin
                    trust_state_next = tcg_pkg::ST_NEVER_SET;
                end else if (in_now_reg < build_floor_reg) begin
                    trust_state_next = tcg_pkg::ST_STOPPED;
                end else if (in_now_reg < in_stored_reg) begin
                    trust_state_next = tcg_pkg::ST_BACKWARDS;
                end else begin
                    trust_state_next = tcg_pkg::ST_OK;
                end
            end
            tcg_pkg::ACT_READ: begin
                time_next = in_now_reg;
                if (trust_state_reg == tcg_pkg::ST_OK) begin
                    if (in_now_reg < high_mark_reg) begin
                        trust_state_next = tcg_pkg::ST_BACKWARDS;
                    end else if ({1'b0, in_now_reg} > mark_plus_interval) begin
                        high_mark_next = in_now_reg;
                        pmark_next     = 1'b1;
                    end
                end
            end
            tcg_pkg::ACT_SET: begin
                accepted_next = 1'b0;
                if (set_ok) begin
                    pprov_next = 1'b1;
                    time_next  = in_epoch_reg;
                    if (in_epoch_reg > high_mark_reg) begin
                        high_mark_next   = in_epoch_reg;
                        pmark_next       = 1'b1;
                        trust_state_next = tcg_pkg::ST_OK;
                        accepted_next    = 1'b1;
                    end else if (in_epoch_reg < high_mark_reg) begin
                        trust_state_next = tcg_pkg::ST_BACKWARDS;
                    end else begin
                        trust_state_next = tcg_pkg::ST_OK;
                        accepted_next    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trust_state_reg <= tcg_pkg::ST_NO_CLOCK;
            high_mark_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                trust_state_reg <= trust_state_next;
                high_mark_reg   <= high_mark_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg   <= 1'b0;
            end
        end
        if (fire) begin
            out_state_reg    <= trust_state_next;
            out_time_reg     <= time_next;
            out_accepted_reg <= accepted_next;
            out_pmark_reg    <= pmark_next;
            out_mark_reg     <= high_mark_next;
            out_pprov_reg    <= pprov_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pprov_reg, out_mark_reg, out_pmark_reg,
                       out_accepted_reg, out_time_reg, out_state_reg};

    // A result always mirrors the state registers until the next event lands.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_mark_reg == high_mark_reg)
                          && (out_state_reg == trust_state_reg))
        else $error("result out of step with the guard state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the result register is empty");

    // A mark write only comes from a read or from a set that leaves the clock trusted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_pmark_reg) |-> out_accepted_reg
                                             && (out_state_reg == tcg_pkg::ST_OK))
        else $error("mark write without a trusted clock");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_pprov_reg) |-> (out_state_reg == tcg_pkg::ST_OK)
                                             || (out_state_reg == tcg_pkg::ST_BACKWARDS))
        else $error("accepted set left an unexpected state");

endmodule
